>>> design/bm25_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_pkg
// Shared widths, constants and the beat type of the BM25 term score pipeline.
// ----------------------------------------------------------------------------
package bm25_pkg;

  // Fraction bits of the output score.
  localparam int FracBits   = 16;
  // The quotient carries 24 fraction bits and idf 16, so the product carries 40.
  localparam int ProdFrac   = 40;
  localparam int RoundShift = ProdFrac - FracBits;

  localparam int TfW    = 16;
  localparam int LenW   = 20;
  localparam int IdfW   = 24;
  localparam int K1W    = 16;
  localparam int BW     = 17;
  localparam int AvgW   = 24;
  localparam int CfgW   = 24;
  localparam int ScoreW = 32;

  // len * 2^24 / avg: 44 quotient bits, two bits retired per stage.
  localparam int RatioShift = 24;
  localparam int RatioW     = LenW + RatioShift;
  localparam int RatioStep  = 2;
  localparam int RatioStages = RatioW / RatioStep;

  // Length norm and denominator widths.
  localparam int BmW  = RatioW + 1;
  localparam int LnW  = BmW + 1;
  localparam int DenW = 62;
  localparam int NumW = K1W + 1 + TfW;
  localparam int DenShift = 28;
  // num * 2^40 / den is below 2^29; the divider starts from num * 2^11.
  localparam int QuotW    = 29;
  localparam int RemShift = ProdFrac - QuotW;
  localparam int ProdW    = IdfW + QuotW;
  localparam int RndW     = ProdW + 1;

  localparam logic [BW-1:0]   OneQ16 = BW'(65536);
  localparam logic [K1W:0]    OneQ12 = (K1W + 1)'(4096);
  localparam logic [AvgW-1:0] OneAvg = AvgW'(256);

  localparam logic [K1W-1:0]  K1Reset  = K1W'(6144);
  localparam logic [BW-1:0]   BReset   = BW'(49152);
  localparam logic [AvgW-1:0] AvgReset = AvgW'(256);

  typedef enum logic [1:0] {
    CfgK1Gain        = 2'd0,
    CfgLengthWeight  = 2'd1,
    CfgAverageLength = 2'd2
  } cfg_idx_e;

  // One item in flight: valid bit plus the fields needed downstream.
  typedef struct packed {
    logic              vld;
    logic [TfW-1:0]    tf;
    logic [IdfW-1:0]   idf;
  } beat_t;

endpackage

>>> design/bm25_ratio_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_ratio_div
// Pipelined restoring divider for floor(len * 2^24 / avg), two bits a stage.
// ----------------------------------------------------------------------------
module bm25_ratio_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              adv_i,
  input  bm25_pkg::beat_t                   beat_i,
  input  logic [bm25_pkg::LenW-1:0]         len_i,
  input  logic [bm25_pkg::AvgW-1:0]         avg_i,
  output bm25_pkg::beat_t                   beat_o,
  output logic [bm25_pkg::RatioW-1:0]       ratio_o
);

  bm25_pkg::beat_t                 beat_q [bm25_pkg::RatioStages];
  logic [bm25_pkg::AvgW-1:0]       rem_q  [bm25_pkg::RatioStages];
  logic [bm25_pkg::RatioW-1:0]     nq_q   [bm25_pkg::RatioStages];

  for (genvar s = 0; s < bm25_pkg::RatioStages; s++) begin : g_stage
    bm25_pkg::beat_t               beat_in;
    logic [bm25_pkg::AvgW-1:0]     rem_in;
    logic [bm25_pkg::RatioW-1:0]   nq_in;
    logic [bm25_pkg::AvgW-1:0]     rem_d;
    logic [bm25_pkg::RatioW-1:0]   nq_d;
    logic [bm25_pkg::AvgW:0]       trial;

    if (s == 0) begin : g_first
      assign beat_in = beat_i;
      assign rem_in  = '0;
      assign nq_in   = {len_i, bm25_pkg::RatioShift'(0)};
    end else begin : g_next
      assign beat_in = beat_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign nq_in   = nq_q[s-1];
    end

    // Numerator bits leave the top of nq while quotient bits enter the bottom.
    always_comb begin
      rem_d = rem_in;
      nq_d  = nq_in;
      trial = '0;
      for (int k = 0; k < bm25_pkg::RatioStep; k++) begin
        trial = {rem_d, nq_d[bm25_pkg::RatioW-1]};
        nq_d  = {nq_d[bm25_pkg::RatioW-2:0], 1'b0};
        if (trial >= {1'b0, avg_i}) begin
          trial   = trial - {1'b0, avg_i};
          nq_d[0] = 1'b1;
        end
        rem_d = trial[bm25_pkg::AvgW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        beat_q[s] <= '0;
      end else if (adv_i) begin
        beat_q[s] <= beat_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s] <= rem_d;
        nq_q[s]  <= nq_d;
      end
    end
  end

  assign beat_o  = beat_q[bm25_pkg::RatioStages-1];
  assign ratio_o = nq_q[bm25_pkg::RatioStages-1];

endmodule

>>> design/bm25_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_norm
// Length norm, denominator and numerator: four register stages.
// ----------------------------------------------------------------------------
module bm25_norm (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  bm25_pkg::beat_t                beat_i,
  input  logic [bm25_pkg::RatioW-1:0]    ratio_i,
  input  logic [bm25_pkg::BW-1:0]        b_i,
  input  logic [bm25_pkg::K1W-1:0]       k1_i,
  output bm25_pkg::beat_t                beat_o,
  output logic [bm25_pkg::DenW-1:0]      den_o,
  output logic [bm25_pkg::DenW-1:0]      rem_o
);

  localparam int BProdW = bm25_pkg::BW + bm25_pkg::RatioW;

  bm25_pkg::beat_t                 beat_b_q, beat_c_q, beat_d_q, beat_e_q;
  logic [BProdW-1:0]               bprod;
  logic [bm25_pkg::BmW-1:0]        bm_q;
  logic [bm25_pkg::LnW-1:0]        ln_d, ln_q;
  logic [bm25_pkg::DenW-1:0]       kl_d, kl_q;
  logic [bm25_pkg::NumW-1:0]       num_d, num_q;
  logic [bm25_pkg::DenW-1:0]       den_d, den_q;
  logic [bm25_pkg::DenW-1:0]       rem_d, rem_q;

  assign bprod = BProdW'(b_i) * BProdW'(ratio_i);
  assign ln_d  = bm25_pkg::LnW'(bm25_pkg::OneQ16) - bm25_pkg::LnW'(b_i)
               + bm25_pkg::LnW'(bm_q);
  assign kl_d  = bm25_pkg::DenW'(k1_i) * bm25_pkg::DenW'(ln_q);
  assign num_d = bm25_pkg::NumW'(k1_i + bm25_pkg::OneQ12) * bm25_pkg::NumW'(beat_c_q.tf);

  always_comb begin
    den_d = (bm25_pkg::DenW'(beat_d_q.tf) << bm25_pkg::DenShift) + kl_q;
    // Replace a zero denominator by 1.0.
    if (den_d == '0) begin
      den_d = bm25_pkg::DenW'(1) << bm25_pkg::DenShift;
    end
    rem_d = bm25_pkg::DenW'(num_q) << bm25_pkg::RemShift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_b_q <= '0;
      beat_c_q <= '0;
      beat_d_q <= '0;
      beat_e_q <= '0;
    end else if (adv_i) begin
      beat_b_q <= beat_i;
      beat_c_q <= beat_b_q;
      beat_d_q <= beat_c_q;
      beat_e_q <= beat_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      bm_q  <= bprod[BProdW-1:16];
      ln_q  <= ln_d;
      kl_q  <= kl_d;
      num_q <= num_d;
      den_q <= den_d;
      rem_q <= rem_d;
    end
  end

  assign beat_o = beat_e_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;

endmodule

>>> design/bm25_quot_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_quot_div
// Pipelined restoring divider for floor(num * 2^40 / den), one bit a stage.
// ----------------------------------------------------------------------------
module bm25_quot_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  bm25_pkg::beat_t               beat_i,
  input  logic [bm25_pkg::DenW-1:0]     den_i,
  input  logic [bm25_pkg::DenW-1:0]     rem_i,
  output bm25_pkg::beat_t               beat_o,
  output logic [bm25_pkg::QuotW-1:0]    quot_o
);

  bm25_pkg::beat_t                 beat_q [bm25_pkg::QuotW];
  logic [bm25_pkg::DenW-1:0]       den_q  [bm25_pkg::QuotW];
  logic [bm25_pkg::DenW-1:0]       rem_q  [bm25_pkg::QuotW];
  logic [bm25_pkg::QuotW-1:0]      quot_q [bm25_pkg::QuotW];

  for (genvar s = 0; s < bm25_pkg::QuotW; s++) begin : g_stage
    bm25_pkg::beat_t               beat_in;
    logic [bm25_pkg::DenW-1:0]     den_in;
    logic [bm25_pkg::DenW-1:0]     rem_in;
    logic [bm25_pkg::QuotW-1:0]    quot_in;
    logic [bm25_pkg::DenW:0]       trial;
    logic                          take;

    if (s == 0) begin : g_first
      assign beat_in = beat_i;
      assign den_in  = den_i;
      assign rem_in  = rem_i;
      assign quot_in = '0;
    end else begin : g_next
      assign beat_in = beat_q[s-1];
      assign den_in  = den_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
    end

    // Remaining numerator bits are all zero: shift in a zero each step.
    assign trial = {rem_in, 1'b0};
    assign take  = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        beat_q[s] <= '0;
      end else if (adv_i) begin
        beat_q[s] <= beat_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        den_q[s]  <= den_in;
        rem_q[s]  <= take ? bm25_pkg::DenW'(trial - {1'b0, den_in})
                          : bm25_pkg::DenW'(trial);
        quot_q[s] <= {quot_in[bm25_pkg::QuotW-2:0], take};
      end
    end
  end

  assign beat_o = beat_q[bm25_pkg::QuotW-1];
  assign quot_o = quot_q[bm25_pkg::QuotW-1];

endmodule

>>> design/bm25_term_score_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_term_score_unit
// Okapi BM25 contribution of one query term to one document, fixed point.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  -----------------------------------------
//  in        in_valid_i / in_stall_o    term_count_i, document_length_i,
//                                       inverse_frequency_i
//  out       out_valid_o / out_stall_i  term_score_o, saturated_o
//  cfg       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
//  One beat enters per cycle unless the output is held. Path: input register,
//  len/avg divider (22 stages, two bits a stage), norm, quotient divider (29
//  stages, one bit a stage), multiply, rounding and output registers.
//  Reset clears every valid bit and loads the default k1, b and average.
//  A stalled output beat holds the whole pipeline; in_stall_o follows it.
//  Config writes are taken in every cycle.
// ----------------------------------------------------------------------------
module bm25_term_score_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bm25_pkg::TfW-1:0]            term_count_i,
  input  logic [bm25_pkg::LenW-1:0]           document_length_i,
  input  logic signed [bm25_pkg::IdfW-1:0]    inverse_frequency_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [bm25_pkg::ScoreW-1:0]  term_score_o,
  output logic                                saturated_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [bm25_pkg::CfgW-1:0]           cfg_data_i
);

  localparam logic [bm25_pkg::RndW-1:0] RoundHalf =
    bm25_pkg::RndW'(1) << (bm25_pkg::RoundShift - 1);
  localparam logic [bm25_pkg::RndW-1:0] LimitPos = bm25_pkg::RndW'(32'h7fff_ffff);
  localparam logic [bm25_pkg::RndW-1:0] LimitNeg = bm25_pkg::RndW'(32'h8000_0000);

  // Configuration registers.
  logic [bm25_pkg::K1W-1:0]   k1_q;
  logic [bm25_pkg::BW-1:0]    lw_q;
  logic [bm25_pkg::AvgW-1:0]  avg_q;
  logic [bm25_pkg::BW-1:0]    b_eff;
  logic [bm25_pkg::AvgW-1:0]  avg_eff;

  // Global advance: drop only when the output beat is held.
  logic                       adv;

  bm25_pkg::beat_t                beat_a_q;
  logic [bm25_pkg::LenW-1:0]      len_a_q;
  bm25_pkg::beat_t                beat_r, beat_n, beat_div;
  logic [bm25_pkg::RatioW-1:0]    ratio;
  logic [bm25_pkg::DenW-1:0]      den, rem;
  logic [bm25_pkg::QuotW-1:0]     quot;

  bm25_pkg::beat_t                beat_f_q, beat_g_q;
  logic [bm25_pkg::IdfW-1:0]      idf_mag;
  logic [bm25_pkg::ProdW-1:0]     prod_q;
  logic [bm25_pkg::RndW-1:0]      rnd_d, rnd_q;

  logic                           out_vld_q;
  logic [bm25_pkg::ScoreW-1:0]    score_d, score_q;
  logic                           sat_d, sat_q;
  logic [bm25_pkg::RndW-1:0]      limit;
  logic [bm25_pkg::ScoreW-1:0]    clip_mag;

  assign adv         = !(out_vld_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Config write decode; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k1_q  <= bm25_pkg::K1Reset;
      lw_q  <= bm25_pkg::BReset;
      avg_q <= bm25_pkg::AvgReset;
    end else if (cfg_valid_i) begin
      unique case (bm25_pkg::cfg_idx_e'(cfg_index_i))
        bm25_pkg::CfgK1Gain:        k1_q  <= cfg_data_i[bm25_pkg::K1W-1:0];
        bm25_pkg::CfgLengthWeight:  lw_q  <= cfg_data_i[bm25_pkg::BW-1:0];
        bm25_pkg::CfgAverageLength: avg_q <= cfg_data_i[bm25_pkg::AvgW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp b to 1.0 and treat a zero average as 1.0.
  assign b_eff   = (lw_q > bm25_pkg::OneQ16) ? bm25_pkg::OneQ16 : lw_q;
  assign avg_eff = (avg_q == '0) ? bm25_pkg::OneAvg : avg_q;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_a_q <= '0;
    end else if (adv) begin
      beat_a_q.vld <= in_valid_i;
      beat_a_q.tf  <= term_count_i;
      beat_a_q.idf <= inverse_frequency_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      len_a_q <= document_length_i;
    end
  end

  bm25_ratio_div u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .beat_i  (beat_a_q),
    .len_i   (len_a_q),
    .avg_i   (avg_eff),
    .beat_o  (beat_r),
    .ratio_o (ratio)
  );

  bm25_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .beat_i  (beat_r),
    .ratio_i (ratio),
    .b_i     (b_eff),
    .k1_i    (k1_q),
    .beat_o  (beat_n),
    .den_o   (den),
    .rem_o   (rem)
  );

  bm25_quot_div u_quot_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .beat_i  (beat_n),
    .den_i   (den),
    .rem_i   (rem),
    .beat_o  (beat_div),
    .quot_o  (quot)
  );

  // Scale by |idf|; the two's complement negate also covers the most negative idf.
  assign idf_mag = beat_div.idf[bm25_pkg::IdfW-1] ? (~beat_div.idf + 1'b1) : beat_div.idf;

  // Round to nearest, ties away from zero, on the magnitude.
  assign rnd_d = (bm25_pkg::RndW'(prod_q) + RoundHalf) >> bm25_pkg::RoundShift;

  // Saturate, then apply the sign; a zero term count forces zero.
  always_comb begin
    limit    = beat_g_q.idf[bm25_pkg::IdfW-1] ? LimitNeg : LimitPos;
    sat_d    = rnd_q > limit;
    clip_mag = sat_d ? limit[bm25_pkg::ScoreW-1:0] : rnd_q[bm25_pkg::ScoreW-1:0];
    score_d  = beat_g_q.idf[bm25_pkg::IdfW-1] ? (~clip_mag + 1'b1) : clip_mag;
    if (beat_g_q.tf == '0) begin
      score_d = '0;
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_f_q  <= '0;
      beat_g_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      beat_f_q  <= beat_div;
      beat_g_q  <= beat_f_q;
      out_vld_q <= beat_g_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q  <= bm25_pkg::ProdW'(idf_mag) * bm25_pkg::ProdW'(quot);
      rnd_q   <= rnd_d;
      score_q <= score_d;
      sat_q   <= sat_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign term_score_o = score_q;
  assign saturated_o  = sat_q;

endmodule

>>> design/bm25_tsu_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bm25_tsu_check
// Port-level assertions for the BM25 term score unit, bound to the top level.
// ----------------------------------------------------------------------------
module bm25_tsu_check (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_stall_o,
  input  logic                                out_valid_o,
  input  logic                                out_stall_i,
  input  logic signed [bm25_pkg::ScoreW-1:0]  term_score_o,
  input  logic                                saturated_o
);

  // A held output beat keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(term_score_o) && $stable(saturated_o))
    else $error("output beat changed while stalled");

  // Input back-pressure only comes from a held output beat.
  a_in_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output");

  // A clipped score sits at one of the range limits.
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      term_score_o == 32'sh7fff_ffff || term_score_o == -32'sh8000_0000)
    else $error("saturated flag with an unclipped score");

  // No output beat right after a reset edge.
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind bm25_term_score_unit bm25_tsu_check u_bm25_tsu_check (.*);
